// ----- hw/rtl/epr_pkg.sv -----
package epr_pkg;

   // Default build values
   localparam int AvgCountDefault  = 5;
   localparam int TimerBitsDefault = 16;

   // Field widths
   localparam int CapBits    = 16;
   localparam int PeriodBits = 17;
   localparam int WrapBits   = 16;
   localparam int TicksBits  = 24;
   localparam int MeasBits   = 26;
   localparam int DistBits   = 9;
   localparam int SumBits    = 12;
   localparam int UsBits     = 32;
   localparam int CsrIdxBits = 4;

   // Fixed limits and reset values
   localparam logic [WrapBits-1:0]  WrapMax      = '1;
   localparam logic [WrapBits-1:0]  TimeoutWraps = 16'd4;
   localparam logic [DistBits-1:0]  MinDist      = 9'd5;
   localparam logic [DistBits-1:0]  DistMax      = '1;
   localparam logic [DistBits-1:0]  DistResetCm  = 9'd450;
   localparam logic [SumBits-1:0]   SumMax       = '1;
   localparam logic [TicksBits-1:0] TicksMax     = '1;
   localparam logic [MeasBits-1:0]  MeasMax      = '1;

   typedef enum logic [1:0] {
      EV_NONE,
      EV_ECHO,
      EV_COLOUR,
      EV_TIMEOUT
   } event_type;

   typedef enum logic [1:0] {
      TRIG_NONE,
      TRIG_ONE,
      TRIG_TWO
   } trig_type;

   typedef enum logic [1:0] {
      CLS_TICK,
      CLS_ECHO,
      CLS_COLOUR
   } class_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_PERIOD,
      CSR_US_PER_TICK,
      CSR_CM_PER_US,
      CSR_AVG_EN,
      CSR_OBST_LIMIT,
      CSR_MAX_DIST,
      CSR_WIN_LOW,
      CSR_WIN_HIGH
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WIDTH,
      ST_US,
      ST_CM,
      ST_COLOUR,
      ST_ECHO,
      ST_MEAN,
      ST_REPORT
   } back_state_type;

   typedef struct packed {
      logic [PeriodBits-1:0] period;
      logic [15:0]           us_per_tick;
      logic [15:0]           cm_per_us;
      logic                  avg_en;
      logic [DistBits-1:0]   obst_limit;
      logic [DistBits-1:0]   max_dist;
      logic [15:0]           win_low;
      logic [15:0]           win_high;
   } cfg_type;

   typedef struct packed {
      class_type          cls;
      logic [1:0]         channel;
      logic [CapBits-1:0] capture;
      logic               armed;
   } item_type;

   typedef struct packed {
      event_type            event_res;
      logic [1:0]           event_channel;
      logic [TicksBits-1:0] pulse_ticks;
      logic [MeasBits-1:0]  measured_value;
      logic [DistBits-1:0]  distance_one;
      logic [DistBits-1:0]  distance_two;
      logic                 distance_updated;
      logic                 obstacle;
      trig_type             trigger_request;
      logic                 colour_in_window;
   } result_type;

endpackage

// ----- hw/rtl/epr_front.sv -----
module epr_front #(
   parameter int TIMER_BITS = epr_pkg::TimerBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_mode,
   input  logic [1:0]                  req_channel,
   input  logic [epr_pkg::CapBits-1:0] req_capture_value,
   input  logic                        req_obstacle_armed,
   output logic                        q_valid,
   output epr_pkg::item_type           q_item,
   input  logic                        q_pop
);
   import epr_pkg::*;

   localparam int CapWidth = (TIMER_BITS < CapBits) ? TIMER_BITS : CapBits;
   localparam logic [CapBits-1:0] CapMask = CapBits'((33'd1 << CapWidth) - 33'd1);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push_ok;
   logic       pop_ok;

   // Classify the incoming event
   always_comb begin
      new_item.channel = req_channel;
      new_item.capture = req_capture_value & CapMask;
      new_item.armed   = req_obstacle_armed;
      if (!req_mode) begin
         new_item.cls = CLS_TICK;
      end else if (req_channel[1]) begin
         new_item.cls = CLS_COLOUR;
      end else begin
         new_item.cls = CLS_ECHO;
      end
   end

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && q_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the item of each input transfer
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- hw/rtl/epr_back.sv -----
module epr_back #(
   parameter int AVG_COUNT = epr_pkg::AvgCountDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  epr_pkg::cfg_type     cfg,
   input  logic                 q_valid,
   input  epr_pkg::item_type    q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output epr_pkg::result_type  rsp,
   input  logic                 rsp_pop
);
   import epr_pkg::*;

   localparam int CntBits  = $clog2(AVG_COUNT + 1);
   localparam int AvgShift = 24;
   localparam logic [AvgShift:0] AvgRecip =
      (AvgShift + 1)'(((64'd1 << AvgShift) + AVG_COUNT - 1) / AVG_COUNT);
   localparam logic [CntBits-1:0] AvgCnt = CntBits'(AVG_COUNT);
   localparam logic [CntBits-1:0] CntOne = CntBits'(1);

   back_state_type state_ff, state_in;
   item_type       item_ff, item_in;
   logic           rise_seen_ff [4];
   logic           rise_seen_in [4];
   logic [CapBits-1:0]  rise_time_ff [4];
   logic [CapBits-1:0]  rise_time_in [4];
   logic [WrapBits-1:0] wrap_ff [4];
   logic [WrapBits-1:0] wrap_in [4];
   logic [WrapBits-1:0] wrap_inc [4];
   logic           exp_two_ff, exp_two_in;
   logic [SumBits-1:0]  sum_ff [2];
   logic [SumBits-1:0]  sum_in [2];
   logic [CntBits-1:0]  cnt_ff [2];
   logic [CntBits-1:0]  cnt_in [2];
   logic [DistBits-1:0] rep_ff [2];
   logic [DistBits-1:0] rep_in [2];
   logic [PeriodBits+WrapBits-1:0] prod_ff, prod_in;
   logic [TicksBits-1:0] ticks_ff, ticks_in;
   logic [UsBits-1:0]    us_ff, us_in;
   logic [DistBits-1:0]  dist_ff, dist_in;
   logic [SumBits-1:0]   acc_ff, acc_in;
   logic                 upd_ff, upd_in;
   result_type           out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   logic [1:0]           ch;
   logic                 es;
   logic signed [34:0]   w_raw;
   logic signed [34:0]   w_fix;
   logic [TicksBits-1:0] ticks_w;
   logic [39:0]          us_prod;
   logic [47:0]          cm_prod;
   logic [30:0]          d_full;
   logic [DistBits-1:0]  dist_clamp;
   logic [MeasBits-1:0]  colour_meas;
   logic [SumBits:0]     sum_add;
   logic [SumBits-1:0]   sum_sat;
   logic [SumBits+AvgShift:0] mean_prod;
   logic [SumBits:0]     mean_q;
   logic [DistBits-1:0]  mean_clamp;
   result_type           res;
   logic                 emit;

   assign ch        = item_ff.channel;
   assign es        = item_ff.channel[0];
   assign rsp       = out_ff;
   assign rsp_valid = out_valid_ff;

   // Datapath terms
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         wrap_inc[i] = (wrap_ff[i] == WrapMax) ? wrap_ff[i] : wrap_ff[i] + 1'b1;
      end
      w_raw = $signed({2'b00, prod_ff}) + $signed(35'(item_ff.capture))
            - $signed(35'(rise_time_ff[ch]));
      w_fix = (w_raw < 0) ? w_raw + $signed(35'(cfg.period)) : w_raw;
      if (w_fix < 0) begin
         ticks_w = '0;
      end else if (w_fix > $signed(35'(TicksMax))) begin
         ticks_w = TicksMax;
      end else begin
         ticks_w = w_fix[TicksBits-1:0];
      end
      us_prod     = 40'(ticks_ff) * 40'(cfg.us_per_tick);
      cm_prod     = 48'(us_ff) * 48'(cfg.cm_per_us);
      d_full      = cm_prod[47:17];
      dist_clamp  = (d_full > 31'(cfg.max_dist)) ? cfg.max_dist : d_full[DistBits-1:0];
      colour_meas = (us_ff > 32'(MeasMax)) ? MeasMax : us_ff[MeasBits-1:0];
      sum_add     = (SumBits+1)'(sum_ff[es]) + (SumBits+1)'(dist_ff);
      sum_sat     = (sum_add > (SumBits+1)'(SumMax)) ? SumMax : sum_add[SumBits-1:0];
      mean_prod   = (SumBits+AvgShift+1)'(acc_ff) * (SumBits+AvgShift+1)'(AvgRecip);
      mean_q      = mean_prod[SumBits+AvgShift:AvgShift];
      mean_clamp  = (mean_q > (SumBits+1)'(DistMax)) ? DistMax : mean_q[DistBits-1:0];
   end

   // Sequence one item through the shared datapath
   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      exp_two_in = exp_two_ff;
      prod_in    = prod_ff;
      ticks_in   = ticks_ff;
      us_in      = us_ff;
      dist_in    = dist_ff;
      acc_in     = acc_ff;
      upd_in     = upd_ff;
      for (int i = 0; i < 4; i++) begin
         rise_seen_in[i] = rise_seen_ff[i];
         rise_time_in[i] = rise_time_ff[i];
         wrap_in[i]      = wrap_ff[i];
      end
      for (int i = 0; i < 2; i++) begin
         sum_in[i] = sum_ff[i];
         cnt_in[i] = cnt_ff[i];
         rep_in[i] = rep_ff[i];
      end
      q_pop = 1'b0;
      emit  = 1'b0;
      res                 = '0;
      res.event_res       = EV_NONE;
      res.trigger_request = TRIG_NONE;
      res.distance_one    = rep_ff[0];
      res.distance_two    = rep_ff[1];

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (item_ff.cls == CLS_TICK) begin
               for (int i = 0; i < 4; i++) begin
                  wrap_in[i] = wrap_inc[i];
               end
               // Echo timeout: restart capture on both echo channels
               if (wrap_inc[0] == TimeoutWraps || wrap_inc[1] == TimeoutWraps) begin
                  wrap_in[0]          = '0;
                  wrap_in[1]          = '0;
                  rise_seen_in[0]     = 1'b0;
                  rise_seen_in[1]     = 1'b0;
                  exp_two_in          = 1'b0;
                  res.event_res       = EV_TIMEOUT;
                  res.trigger_request = TRIG_ONE;
               end
               emit = 1'b1;
            end else if (item_ff.cls == CLS_ECHO && es != exp_two_ff) begin
               emit = 1'b1;
            end else if (!rise_seen_ff[ch]) begin
               rise_time_in[ch] = item_ff.capture;
               rise_seen_in[ch] = 1'b1;
               wrap_in[ch]      = '0;
               emit             = 1'b1;
            end else begin
               rise_seen_in[ch] = 1'b0;
               prod_in  = (PeriodBits+WrapBits)'(wrap_ff[ch])
                        * (PeriodBits+WrapBits)'(cfg.period);
               state_in = ST_WIDTH;
            end
         end
         ST_WIDTH: begin
            ticks_in = ticks_w;
            state_in = ST_US;
         end
         ST_US: begin
            us_in    = us_prod[39:8];
            state_in = (item_ff.cls == CLS_COLOUR) ? ST_COLOUR : ST_CM;
         end
         ST_COLOUR: begin
            res.event_res        = EV_COLOUR;
            res.event_channel    = ch;
            res.pulse_ticks      = ticks_ff;
            res.measured_value   = colour_meas;
            res.colour_in_window = (colour_meas > MeasBits'(cfg.win_low))
                                && (colour_meas < MeasBits'(cfg.win_high));
            emit = 1'b1;
         end
         ST_CM: begin
            dist_in  = dist_clamp;
            state_in = ST_ECHO;
         end
         ST_ECHO: begin
            upd_in     = 1'b0;
            exp_two_in = !es;
            state_in   = ST_REPORT;
            if (dist_ff > MinDist) begin
               if (cfg.avg_en) begin
                  if (cnt_ff[es] < AvgCnt) begin
                     cnt_in[es] = cnt_ff[es] + 1'b1;
                     sum_in[es] = sum_sat;
                  end else begin
                     acc_in   = sum_sat;
                     state_in = ST_MEAN;
                  end
               end else begin
                  rep_in[es] = dist_ff;
                  upd_in     = 1'b1;
               end
            end
         end
         ST_MEAN: begin
            rep_in[es] = mean_clamp;
            cnt_in[es] = CntOne;
            sum_in[es] = '0;
            upd_in     = 1'b1;
            state_in   = ST_REPORT;
         end
         ST_REPORT: begin
            res.event_res        = EV_ECHO;
            res.event_channel    = ch;
            res.pulse_ticks      = ticks_ff;
            res.measured_value   = MeasBits'(dist_ff);
            res.distance_updated = upd_ff;
            res.obstacle         = upd_ff && item_ff.armed
                                && (rep_ff[0] < cfg.obst_limit || rep_ff[1] < cfg.obst_limit);
            res.trigger_request  = es ? TRIG_ONE : TRIG_TWO;
            emit = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Output slot: drop on a result transfer, load on emit
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_in       = res;
         out_valid_in = 1'b1;
         state_in     = ST_IDLE;
      end
   end

   // Control and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         exp_two_ff   <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            rise_seen_ff[i] <= 1'b0;
            rise_time_ff[i] <= '0;
            wrap_ff[i]      <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= CntOne;
            rep_ff[i] <= DistResetCm;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         exp_two_ff   <= exp_two_in;
         for (int i = 0; i < 4; i++) begin
            rise_seen_ff[i] <= rise_seen_in[i];
            rise_time_ff[i] <= rise_time_in[i];
            wrap_ff[i]      <= wrap_in[i];
         end
         for (int i = 0; i < 2; i++) begin
            sum_ff[i] <= sum_in[i];
            cnt_ff[i] <= cnt_in[i];
            rep_ff[i] <= rep_in[i];
         end
      end
   end

   // Working registers of the datapath
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      prod_ff  <= prod_in;
      ticks_ff <= ticks_in;
      us_ff    <= us_in;
      dist_ff  <= dist_in;
      acc_ff   <= acc_in;
      upd_ff   <= upd_in;
      out_ff   <= out_in;
   end

endmodule

// ----- hw/rtl/echo_pulse_ranging_capture.sv -----
// Echo pulse ranging and colour pulse capture.
// Input queue: drive req_mode/req_channel/req_capture_value/req_obstacle_armed
// and raise req_push; the transfer happens on a clock edge with req_full low.
// A tick (mode 0) steps the overflow counts; an edge (mode 1) is a rising or
// falling capture on one of four channels.
// Result queue: while rsp_empty is low the oldest result sits on the rsp_
// ports; raise rsp_pop to take it. Every input item yields one result.
// Configuration: csr_index/csr_data with csr_valid; csr_ready is always high.
// Write only while the block is idle.
// A tick, a rising edge or an ignored edge yields its result at dispatch; a
// colour falling edge passes the width, us and colour states, an echo one the
// width, us, cm, echo and report states (and mean, when a mean is formed).
// One item at a time runs through the shared multiplier sequencer, which sets
// the rate; a two-entry input queue takes further items meanwhile.
// A stalled result holds the sequencer once its result slot is full; the
// input queue then fills and req_full rises.
// Reset (synchronous) empties both queues, loads the default registers,
// resets all channel state and selects echo sensor one.
module echo_pulse_ranging_capture #(
   parameter int AVG_COUNT  = epr_pkg::AvgCountDefault,
   parameter int TIMER_BITS = epr_pkg::TimerBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_mode,
   input  logic [1:0]                     req_channel,
   input  logic [epr_pkg::CapBits-1:0]    req_capture_value,
   input  logic                           req_obstacle_armed,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [1:0]                     rsp_event_res,
   output logic [1:0]                     rsp_event_channel,
   output logic [epr_pkg::TicksBits-1:0]  rsp_pulse_ticks,
   output logic [epr_pkg::MeasBits-1:0]   rsp_measured_value,
   output logic [epr_pkg::DistBits-1:0]   rsp_distance_one,
   output logic [epr_pkg::DistBits-1:0]   rsp_distance_two,
   output logic                           rsp_distance_updated,
   output logic                           rsp_obstacle,
   output logic [1:0]                     rsp_trigger_request,
   output logic                           rsp_colour_in_window,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [epr_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [epr_pkg::PeriodBits-1:0] csr_data
);
   import epr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       q_valid;
   item_type   q_item;
   logic       q_pop;
   logic       rsp_valid;
   result_type rsp;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PERIOD:      cfg_in.period      = csr_data;
            CSR_US_PER_TICK: cfg_in.us_per_tick = csr_data[15:0];
            CSR_CM_PER_US:   cfg_in.cm_per_us   = csr_data[15:0];
            CSR_AVG_EN:      cfg_in.avg_en      = csr_data[0];
            CSR_OBST_LIMIT:  cfg_in.obst_limit  = csr_data[DistBits-1:0];
            CSR_MAX_DIST:    cfg_in.max_dist    = csr_data[DistBits-1:0];
            CSR_WIN_LOW:     cfg_in.win_low     = csr_data[15:0];
            CSR_WIN_HIGH:    cfg_in.win_high    = csr_data[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period      <= 17'd65535;
         cfg_ff.us_per_tick <= 16'd683;
         cfg_ff.cm_per_us   <= 16'd2248;
         cfg_ff.avg_en      <= 1'b0;
         cfg_ff.obst_limit  <= 9'd35;
         cfg_ff.max_dist    <= DistResetCm;
         cfg_ff.win_low     <= 16'd100;
         cfg_ff.win_high    <= 16'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   epr_front #(
      .TIMER_BITS(TIMER_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_channel        (req_channel),
      .req_capture_value  (req_capture_value),
      .req_obstacle_armed (req_obstacle_armed),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   epr_back #(
      .AVG_COUNT(AVG_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty            = !rsp_valid;
   assign rsp_event_res        = rsp.event_res;
   assign rsp_event_channel    = rsp.event_channel;
   assign rsp_pulse_ticks      = rsp.pulse_ticks;
   assign rsp_measured_value   = rsp.measured_value;
   assign rsp_distance_one     = rsp.distance_one;
   assign rsp_distance_two     = rsp.distance_two;
   assign rsp_distance_updated = rsp.distance_updated;
   assign rsp_obstacle         = rsp.obstacle;
   assign rsp_trigger_request  = rsp.trigger_request;
   assign rsp_colour_in_window = rsp.colour_in_window;

endmodule

// ----- hw/rtl/epr_checker.sv -----
module epr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic [1:0] rsp_event_res,
   input logic [1:0] rsp_event_channel,
   input logic       rsp_distance_updated,
   input logic       rsp_obstacle,
   input logic [1:0] rsp_trigger_request
);
   import epr_pkg::*;

   // Both queues empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // An event of nothing carries no trigger and no update
   a_none_quiet: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_res == EV_NONE) |->
         (rsp_trigger_request == TRIG_NONE && !rsp_distance_updated))
      else $error("empty event carries a request");

   // An obstacle is reported only with a fresh distance
   a_obstacle_upd: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_obstacle) |-> (rsp_distance_updated && rsp_event_res == EV_ECHO))
      else $error("obstacle without distance update");

   // A timeout restarts on sensor one
   a_timeout_trig: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_res == EV_TIMEOUT) |->
         (rsp_trigger_request == TRIG_ONE && rsp_event_channel == 2'd0))
      else $error("timeout does not trigger sensor one");

   // An echo result always requests the other sensor
   a_echo_trig: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_res == EV_ECHO) |->
         ((rsp_event_channel == 2'd0 && rsp_trigger_request == TRIG_TWO) ||
          (rsp_event_channel == 2'd1 && rsp_trigger_request == TRIG_ONE)))
      else $error("echo result requests the wrong sensor");

endmodule

bind echo_pulse_ranging_capture epr_checker u_epr_checker (
   .clock                (clock),
   .reset                (reset),
   .req_full             (req_full),
   .rsp_empty            (rsp_empty),
   .rsp_event_res        (rsp_event_res),
   .rsp_event_channel    (rsp_event_channel),
   .rsp_distance_updated (rsp_distance_updated),
   .rsp_obstacle         (rsp_obstacle),
   .rsp_trigger_request  (rsp_trigger_request)
);

// ----- sim/tb_echo_pulse_ranging_capture.sv -----
module tb_echo_pulse_ranging_capture;
   import epr_pkg::*;

   localparam int CycleLimit = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_mode = 1'b0;
   logic [1:0]            req_channel = 2'd0;
   logic [CapBits-1:0]    req_capture_value = '0;
   logic                  req_obstacle_armed = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [1:0]            rsp_event_res;
   logic [1:0]            rsp_event_channel;
   logic [TicksBits-1:0]  rsp_pulse_ticks;
   logic [MeasBits-1:0]   rsp_measured_value;
   logic [DistBits-1:0]   rsp_distance_one;
   logic [DistBits-1:0]   rsp_distance_two;
   logic                  rsp_distance_updated;
   logic                  rsp_obstacle;
   logic [1:0]            rsp_trigger_request;
   logic                  rsp_colour_in_window;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CsrIdxBits-1:0] csr_index = '0;
   logic [PeriodBits-1:0] csr_data = '0;

   echo_pulse_ranging_capture dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow registers and channel state of the ranging block
   cfg_type          shadow_cfg;
   logic             ch_armed_rise [4];
   logic [15:0]      ch_rise_time [4];
   logic [15:0]      ch_wraps [4];
   logic [1:0]       next_echo;
   logic [11:0]      dist_sum [2];
   logic [2:0]       dist_samples [2];
   logic [8:0]       dist_reported [2];

   result_type       pending_results [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               results_seen = 0;
   int               echo_seen = 0;
   int               colour_seen = 0;
   int               timeout_seen = 0;
   bit               rsp_hold_long = 0;

   // directed rows: a typed expectation is checked only where has_known is set
   typedef struct {
      logic        mode;
      logic [1:0]  channel;
      logic [15:0] capture;
      logic        armed;
      bit          has_known;
      result_type  known;
   } stim_row;

   result_type known_results [$];
   bit         known_valid [$];

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic reset_ranging_state();
      shadow_cfg = '{period: 17'd65535, us_per_tick: 16'd683, cm_per_us: 16'd2248,
                     avg_en: 1'b0, obst_limit: 9'd35, max_dist: 9'd450,
                     win_low: 16'd100, win_high: 16'd500};
      for (int i = 0; i < 4; i++) begin
         ch_armed_rise[i] = 0;
         ch_rise_time[i] = '0;
         ch_wraps[i] = '0;
      end
      next_echo = 2'd1;
      for (int s = 0; s < 2; s++) begin
         dist_sum[s] = '0;
         dist_samples[s] = 3'd1;
         dist_reported[s] = 9'd450;
      end
   endtask

   function automatic result_type predict_capture(input logic mode, input logic [1:0] ch,
                                                  input logic [15:0] cap, input logic armed);
      result_type r;
      longint w;
      longint unsigned us, d64;
      logic [8:0] d, m;
      logic upd;
      r = '0;
      r.event_res = EV_NONE;
      r.trigger_request = TRIG_NONE;
      upd = 0;
      if (mode == 1'b0) begin
         for (int i = 0; i < 4; i++) if (ch_wraps[i] != 16'hFFFF) ch_wraps[i]++;
         if (ch_wraps[0] == 16'd4 || ch_wraps[1] == 16'd4) begin
            ch_wraps[0] = '0; ch_wraps[1] = '0;
            ch_armed_rise[0] = 0; ch_armed_rise[1] = 0;
            next_echo = 2'd1;
            r.event_res = EV_TIMEOUT;
            r.trigger_request = TRIG_ONE;
         end
      end else if (ch < 2 && next_echo != ch + 2'd1) begin
         // edge on the echo channel that is not expected: drop it
      end else if (!ch_armed_rise[ch]) begin
         ch_rise_time[ch] = cap;
         ch_armed_rise[ch] = 1;
         ch_wraps[ch] = '0;
      end else begin
         ch_armed_rise[ch] = 0;
         w = longint'(ch_wraps[ch]) * longint'(shadow_cfg.period) + longint'(cap)
             - longint'(ch_rise_time[ch]);
         if (w < 0) w += longint'(shadow_cfg.period);
         if (w < 0) w = 0;
         if (w > 64'hFFFFFF) w = 64'hFFFFFF;
         r.pulse_ticks = w[23:0];
         us = (longint'(w) * longint'(shadow_cfg.us_per_tick)) >> 8;
         r.event_channel = ch;
         if (ch >= 2) begin
            r.measured_value = us > 64'h3FFFFFF ? 26'h3FFFFFF : us[25:0];
            r.colour_in_window = (r.measured_value > shadow_cfg.win_low &&
                                  r.measured_value < shadow_cfg.win_high);
            r.event_res = EV_COLOUR;
         end else begin
            d64 = (us * longint'(shadow_cfg.cm_per_us)) >> 17;
            d = d64 > shadow_cfg.max_dist ? shadow_cfg.max_dist : d64[8:0];
            r.measured_value = 26'(d);
            r.event_res = EV_ECHO;
            if (d > 9'd5) begin
               if (shadow_cfg.avg_en) begin
                  if (int'(dist_sum[ch[0]]) + d > 4095) dist_sum[ch[0]] = 12'hFFF;
                  else dist_sum[ch[0]] = dist_sum[ch[0]] + 12'(d);
                  if (dist_samples[ch[0]] < 3'd5) dist_samples[ch[0]]++;
                  else begin
                     m = (dist_sum[ch[0]] / 5 > 511) ? 9'd511 : 9'(dist_sum[ch[0]] / 5);
                     dist_reported[ch[0]] = m;
                     dist_samples[ch[0]] = 3'd1;
                     dist_sum[ch[0]] = '0;
                     upd = 1;
                  end
               end else begin
                  dist_reported[ch[0]] = d;
                  upd = 1;
               end
               r.obstacle = upd && armed && (dist_reported[0] < shadow_cfg.obst_limit ||
                                             dist_reported[1] < shadow_cfg.obst_limit);
            end
            next_echo = ch[0] ? 2'd1 : 2'd2;
            r.trigger_request = ch[0] ? TRIG_ONE : TRIG_TWO;
         end
      end
      r.distance_one = dist_reported[0];
      r.distance_two = dist_reported[1];
      r.distance_updated = upd;
      return r;
   endfunction

   // transfer one item and record its expected result; push stays high for a follow-on item
   task automatic push_capture(input logic mode, input logic [1:0] ch, input logic [15:0] cap,
                               input logic armed, input bit has_known, input result_type known,
                               input int gap);
      result_type r;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_mode <= mode;
      req_channel <= ch;
      req_capture_value <= cap;
      req_obstacle_armed <= armed;
      @(posedge clock);
      while (req_full) @(posedge clock);
      r = predict_capture(mode, ch, cap, armed);
      pending_results.push_back(r);
      known_results.push_back(known);
      known_valid.push_back(has_known);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= PeriodBits'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_PERIOD:      shadow_cfg.period = PeriodBits'(value);
         CSR_US_PER_TICK: shadow_cfg.us_per_tick = 16'(value);
         CSR_CM_PER_US:   shadow_cfg.cm_per_us = 16'(value);
         CSR_AVG_EN:      shadow_cfg.avg_en = value[0];
         CSR_OBST_LIMIT:  shadow_cfg.obst_limit = 9'(value);
         CSR_MAX_DIST:    shadow_cfg.max_dist = 9'(value);
         CSR_WIN_LOW:     shadow_cfg.win_low = 16'(value);
         CSR_WIN_HIGH:    shadow_cfg.win_high = 16'(value);
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      result_type w;
      result_type k;
      bit kv;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_event_res, -1);
         end else begin
            w = pending_results.pop_front();
            k = known_results.pop_front();
            kv = known_valid.pop_front();
            if (kv && k != w) report_mismatch("directed row disagrees with predictor", 0, 0);
            case (w.event_res)
               EV_ECHO:    echo_seen++;
               EV_COLOUR:  colour_seen++;
               EV_TIMEOUT: timeout_seen++;
               default: ;
            endcase
            if (rsp_event_res != w.event_res)
               report_mismatch("event_res", rsp_event_res, w.event_res);
            if (rsp_event_channel != w.event_channel)
               report_mismatch("event_channel", rsp_event_channel, w.event_channel);
            if (rsp_pulse_ticks != w.pulse_ticks)
               report_mismatch("pulse_ticks", rsp_pulse_ticks, w.pulse_ticks);
            if (rsp_measured_value != w.measured_value)
               report_mismatch("measured_value", rsp_measured_value, w.measured_value);
            if (rsp_distance_one != w.distance_one)
               report_mismatch("distance_one", rsp_distance_one, w.distance_one);
            if (rsp_distance_two != w.distance_two)
               report_mismatch("distance_two", rsp_distance_two, w.distance_two);
            if (rsp_distance_updated != w.distance_updated)
               report_mismatch("distance_updated", rsp_distance_updated, w.distance_updated);
            if (rsp_obstacle != w.obstacle)
               report_mismatch("obstacle", rsp_obstacle, w.obstacle);
            if (rsp_trigger_request != w.trigger_request)
               report_mismatch("trigger_request", rsp_trigger_request, w.trigger_request);
            if (rsp_colour_in_window != w.colour_in_window)
               report_mismatch("colour_in_window", rsp_colour_in_window, w.colour_in_window);
         end
      end
   end

   // receiver: random stalls per result, and one long hold-off on request
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (rsp_hold_long) begin
            rsp_pop <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_hold_long = 0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   function automatic result_type quiet_result(input logic [8:0] d1, input logic [8:0] d2);
      result_type r;
      r = '0;
      r.event_res = EV_NONE;
      r.trigger_request = TRIG_NONE;
      r.distance_one = d1;
      r.distance_two = d2;
      return r;
   endfunction

   // one echo pulse on the expected sensor, or a colour pulse, a tick or noise
   task automatic random_item(input bit burst);
      int sel;
      logic [1:0] ch;
      logic [15:0] rise;
      int gap;
      gap = burst ? 0 : $urandom_range(0, 14);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         ch = next_echo - 2'd1;
         rise = 16'($urandom);
         push_capture(1, ch, rise, 0, 0, '0, gap);
         if ($urandom_range(0, 3) == 0)
            push_capture(0, 0, 0, 0, 0, '0, burst ? 0 : $urandom_range(0, 14));
         push_capture(1, ch, ($urandom_range(0, 1) ? rise + 16'($urandom_range(0, 6000))
                                                   : 16'($urandom)),
                      1'($urandom_range(0, 1)), 0, '0, burst ? 0 : $urandom_range(0, 14));
      end else if (sel < 70) begin
         ch = 2'($urandom_range(2, 3));
         push_capture(1, ch, 16'($urandom), 0, 0, '0, gap);
         push_capture(1, ch, 16'($urandom), 1'($urandom_range(0, 1)), 0, '0,
                      burst ? 0 : $urandom_range(0, 14));
      end else if (sel < 85) begin
         push_capture(0, 2'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), 0, '0, gap);
      end else begin
         push_capture(1, 2'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), 0, '0, gap);
      end
   endtask

   initial begin
      stim_row rows [$];
      stim_row row;
      result_type k;
      reset_ranging_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: ticks, rises, falls, ignored edges, timeouts, extremes
      k = quiet_result(9'd450, 9'd450);
      rows.push_back('{0, 2'd0, 16'd0, 0, 1, k});
      rows.push_back('{1, 2'd1, 16'hFFFF, 1, 1, k});
      rows.push_back('{1, 2'd0, 16'd100, 0, 1, k});
      rows.push_back('{1, 2'd0, 16'd200, 1, 0, k});
      rows.push_back('{1, 2'd1, 16'd0, 0, 1, k});
      rows.push_back('{1, 2'd1, 16'hFFFF, 1, 0, k});
      rows.push_back('{1, 2'd2, 16'hFFFF, 0, 1, k});
      rows.push_back('{1, 2'd2, 16'd0, 0, 0, k});
      rows.push_back('{1, 2'd3, 16'd1000, 0, 1, k});
      rows.push_back('{0, 2'd3, 16'd0, 0, 0, k});
      rows.push_back('{1, 2'd3, 16'd999, 0, 0, k});
      rows.push_back('{1, 2'd0, 16'd5000, 0, 0, k});
      for (int i = 0; i < 4; i++) rows.push_back('{0, 2'd0, 16'd0, 0, 0, k});
      rows.push_back('{1, 2'd0, 16'd10, 0, 0, k});
      rows.push_back('{1, 2'd0, 16'd10, 1, 0, k});
      foreach (rows[i]) begin
         row = rows[i];
         push_capture(row.mode, row.channel, row.capture, row.armed, row.has_known,
                      row.known, $urandom_range(0, 3));
      end
      drain_results();

      // extremes of the registers
      write_csr(CSR_PERIOD, 65536);
      write_csr(CSR_US_PER_TICK, 65535);
      write_csr(CSR_CM_PER_US, 65535);
      write_csr(CSR_MAX_DIST, 511);
      write_csr(CSR_OBST_LIMIT, 511);
      write_csr(CSR_WIN_LOW, 0);
      write_csr(CSR_WIN_HIGH, 65535);
      write_csr(CSR_AVG_EN, 0);
      push_capture(1, next_echo - 2'd1, 16'hFFFF, 1, 0, '0, 0);
      for (int i = 0; i < 3; i++) push_capture(0, 0, 0, 0, 0, '0, 0);
      push_capture(1, next_echo - 2'd1, 16'd0, 1, 0, '0, 0);
      push_capture(1, 2'd2, 16'hFFFF, 0, 0, '0, 0);
      for (int i = 0; i < 3; i++) push_capture(0, 0, 0, 0, 0, '0, 0);
      push_capture(1, 2'd2, 16'hFFFF, 0, 0, '0, 0);
      for (int i = 0; i < 60; i++) random_item(0);
      drain_results();

      // zero period, small scale, averaging on
      write_csr(CSR_PERIOD, 0);
      write_csr(CSR_US_PER_TICK, 1);
      write_csr(CSR_CM_PER_US, 1);
      write_csr(CSR_AVG_EN, 1);
      write_csr(CSR_MAX_DIST, 0);
      write_csr(CSR_OBST_LIMIT, 0);
      for (int i = 0; i < 40; i++) random_item(0);
      drain_results();

      // default period and scales with averaging: long hold-off while the sender floods
      write_csr(CSR_PERIOD, 65535);
      write_csr(CSR_US_PER_TICK, 683);
      write_csr(CSR_CM_PER_US, 2248);
      write_csr(CSR_MAX_DIST, 450);
      write_csr(CSR_OBST_LIMIT, 120);
      write_csr(CSR_WIN_LOW, 100);
      write_csr(CSR_WIN_HIGH, 3000);
      rsp_hold_long = 1;
      for (int i = 0; i < 30; i++) random_item(1);
      for (int i = 0; i < 90; i++) random_item(0);
      drain_results();

      // random settings per phase
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CSR_PERIOD, $urandom_range(1, 65536));
         write_csr(CSR_US_PER_TICK, $urandom_range(1, 4000));
         write_csr(CSR_CM_PER_US, $urandom_range(1, 65535));
         write_csr(CSR_AVG_EN, $urandom_range(0, 1));
         write_csr(CSR_OBST_LIMIT, $urandom_range(0, 511));
         write_csr(CSR_MAX_DIST, $urandom_range(0, 511));
         write_csr(CSR_WIN_LOW, $urandom_range(0, 2000));
         write_csr(CSR_WIN_HIGH, $urandom_range(0, 65535));
         for (int i = 0; i < 35; i++) random_item($urandom_range(0, 4) == 0);
         drain_results();
      end

      $display("covered %0d results: %0d echo, %0d colour, %0d timeout, several settings",
               results_seen, echo_seen, colour_seen, timeout_seen);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
